>>> hw/rtl/pileup_read_string_parser_unit_assert.svh
// Assertion macros shared by the parser unit.
`ifndef PILEUP_READ_STRING_PARSER_UNIT_ASSERT_SVH
`define PILEUP_READ_STRING_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPRSP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPRSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pprsp_pkg.sv
package pprsp_pkg;

   localparam int COUNT_BITS = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [COUNT_BITS+3:0] wide_type;
   typedef logic [15:0] index_type;
   typedef logic [15:0] depth_type;
   typedef logic [7:0] byte_type;
   typedef logic [2:0] base_type;
   typedef logic [6:0] phred_type;
   typedef logic signed [19:0] mult_type;
   typedef logic signed [26:0] lerr_type;

   localparam mult_type MULT_RESET = -20'sd15090;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_READ   = 2'd1,
      OP_QUAL   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_BASE   = 2'd0,
      KIND_QUAL   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TRAILING = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_CARET  = 4'b0010,
      MODE_DIGITS = 4'b0100,
      MODE_SKIP   = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_MARK = 2'd1,
      TAIL_JUNK = 2'd2,
      TAIL_QUAL = 2'd3
   } tail_type;

   localparam base_type BASE_A       = 3'd0;
   localparam base_type BASE_C       = 3'd1;
   localparam base_type BASE_G       = 3'd2;
   localparam base_type BASE_T       = 3'd3;
   localparam base_type BASE_DELETED = 3'd4;
   localparam base_type BASE_UNKNOWN = 3'd5;
   localparam base_type BASE_INVALID = 3'd6;

   localparam byte_type CHAR_CARET   = 8'h5E;
   localparam byte_type CHAR_DOLLAR  = 8'h24;
   localparam byte_type CHAR_PLUS    = 8'h2B;
   localparam byte_type CHAR_MINUS   = 8'h2D;
   localparam byte_type CHAR_STAR    = 8'h2A;
   localparam byte_type CHAR_DOT     = 8'h2E;
   localparam byte_type CHAR_COMMA   = 8'h2C;
   localparam byte_type CHAR_ZERO    = 8'h30;
   localparam byte_type CHAR_NINE    = 8'h39;
   localparam byte_type CHAR_UPPER_A = 8'h41;
   localparam byte_type CHAR_LOWER_A = 8'h61;
   localparam byte_type CHAR_UPPER_C = 8'h43;
   localparam byte_type CHAR_LOWER_C = 8'h63;
   localparam byte_type CHAR_UPPER_G = 8'h47;
   localparam byte_type CHAR_LOWER_G = 8'h67;
   localparam byte_type CHAR_UPPER_T = 8'h54;
   localparam byte_type CHAR_LOWER_T = 8'h74;
   localparam byte_type CHAR_UPPER_N = 8'h4E;
   localparam byte_type CHAR_LOWER_N = 8'h6E;

   localparam byte_type PHRED_OFFSET = 8'd33;
   localparam byte_type PHRED_TOP    = 8'd126;
   localparam phred_type PHRED_MAX   = 7'd93;

   typedef struct packed {
      op_type    op;
      base_type  base;
      logic      is_ref;
      logic      is_caret;
      logic      is_dollar;
      logic      is_sign;
      logic      is_digit;
      logic [3:0] digit;
      phred_type phred;
      base_type  ref_code;
      count_type depth;
   } item_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [QCNT_BITS-1:0] count;
   } queue_stat_type;

endpackage

>>> hw/rtl/pprsp_req_if.sv
interface pprsp_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [7:0]                 data_byte;
   logic [2:0]                 ref_base;
   logic [15:0]                depth;

   modport source (output valid, op, data_byte, ref_base, depth, input ready);
   modport sink (input valid, op, data_byte, ref_base, depth, output ready);
endinterface

>>> hw/rtl/pprsp_rsp_if.sv
interface pprsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         base_code;
   logic [15:0]        read_index;
   logic signed [26:0] log_error;
   logic [1:0]         status;

   modport source (output valid, kind, base_code, read_index, log_error, status,
                   input ready);
   modport sink (input valid, kind, base_code, read_index, log_error, status,
                 output ready);
endinterface

>>> hw/rtl/pprsp_front.sv
module pprsp_front (
   pprsp_req_if.sink               req_bus,
   input  pprsp_pkg::queue_stat_type q_stat,
   output logic                    push,
   output pprsp_pkg::item_type     item
);

   pprsp_pkg::byte_type b;

   assign b = req_bus.data_byte;
   assign req_bus.ready = !q_stat.full;
   assign push = req_bus.valid && !q_stat.full;

   always_comb begin
      item = '0;
      item.op = pprsp_pkg::op_type'(req_bus.op);
      item.depth = pprsp_pkg::count_type'(req_bus.depth);
      item.ref_code = (req_bus.ref_base > pprsp_pkg::BASE_INVALID) ?
                      pprsp_pkg::BASE_INVALID : req_bus.ref_base;
      item.is_caret = (b == pprsp_pkg::CHAR_CARET);
      item.is_dollar = (b == pprsp_pkg::CHAR_DOLLAR);
      item.is_sign = (b == pprsp_pkg::CHAR_PLUS) || (b == pprsp_pkg::CHAR_MINUS);
      item.is_digit = (b >= pprsp_pkg::CHAR_ZERO) && (b <= pprsp_pkg::CHAR_NINE);
      item.digit = 4'(b - pprsp_pkg::CHAR_ZERO);
      unique case (b) inside
         pprsp_pkg::CHAR_UPPER_A, pprsp_pkg::CHAR_LOWER_A: item.base = pprsp_pkg::BASE_A;
         pprsp_pkg::CHAR_UPPER_C, pprsp_pkg::CHAR_LOWER_C: item.base = pprsp_pkg::BASE_C;
         pprsp_pkg::CHAR_UPPER_G, pprsp_pkg::CHAR_LOWER_G: item.base = pprsp_pkg::BASE_G;
         pprsp_pkg::CHAR_UPPER_T, pprsp_pkg::CHAR_LOWER_T: item.base = pprsp_pkg::BASE_T;
         pprsp_pkg::CHAR_DOT, pprsp_pkg::CHAR_COMMA: begin
            item.base = pprsp_pkg::BASE_A;
            item.is_ref = 1'b1;
         end
         pprsp_pkg::CHAR_STAR: item.base = pprsp_pkg::BASE_DELETED;
         pprsp_pkg::CHAR_UPPER_N, pprsp_pkg::CHAR_LOWER_N: item.base = pprsp_pkg::BASE_UNKNOWN;
         default: item.base = pprsp_pkg::BASE_INVALID;
      endcase
      if (b < pprsp_pkg::PHRED_OFFSET) begin
         item.phred = '0;
      end else if (b > pprsp_pkg::PHRED_TOP) begin
         item.phred = pprsp_pkg::PHRED_MAX;
      end else begin
         item.phred = pprsp_pkg::phred_type'(b - pprsp_pkg::PHRED_OFFSET);
      end
   end

endmodule

>>> hw/rtl/pprsp_queue.sv
module pprsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pprsp_pkg::item_type       push_item,
   input  logic                      pop,
   output pprsp_pkg::item_type       head_item,
   output pprsp_pkg::queue_stat_type q_stat
);

   pprsp_pkg::item_type entries_ff [pprsp_pkg::QUEUE_DEPTH];
   logic [pprsp_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pprsp_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pprsp_pkg::QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [pprsp_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [pprsp_pkg::QPTR_BITS-1:0] p
   );
      if (p == pprsp_pkg::QPTR_BITS'(pprsp_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full = (count_ff == pprsp_pkg::QCNT_BITS'(pprsp_pkg::QUEUE_DEPTH));
   assign q_stat.count = count_ff;
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/pprsp_back.sv
module pprsp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic signed [19:0]        csr_wdata,
   input  pprsp_pkg::queue_stat_type q_stat,
   input  pprsp_pkg::item_type       item,
   output logic                      pop,
   pprsp_rsp_if.source               rsp_bus
);

   pprsp_pkg::mult_type  mult_ff;
   pprsp_pkg::mode_type  mode_ff, mode_in;
   pprsp_pkg::tail_type  tail_ff, tail_in;
   pprsp_pkg::count_type skip_ff, skip_in;
   pprsp_pkg::count_type indel_ff, indel_in;
   pprsp_pkg::count_type reads_ff, reads_in;
   pprsp_pkg::count_type quals_ff, quals_in;
   pprsp_pkg::count_type depth_ff, depth_in;
   pprsp_pkg::base_type  refc_ff, refc_in;
   logic                 valid_ff, valid_in;
   pprsp_pkg::kind_type  kind_ff, kind_in;
   pprsp_pkg::base_type  base_ff, base_in;
   pprsp_pkg::index_type index_ff, index_in;
   pprsp_pkg::lerr_type  lerr_ff, lerr_in;
   pprsp_pkg::status_type status_ff, status_in;
   logic                 emit;
   logic                 do_normal;
   logic                 is_marker;
   pprsp_pkg::count_type skip_dec;
   pprsp_pkg::wide_type  indel_wide;
   pprsp_pkg::wide_type  indel_next;
   pprsp_pkg::count_type indel_sat;
   pprsp_pkg::lerr_type  phred_x;
   pprsp_pkg::lerr_type  mult_x;

   assign pop = !q_stat.empty && (!valid_ff || rsp_bus.ready);
   assign is_marker = item.is_caret || item.is_dollar || item.is_sign;
   assign skip_dec = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;
   assign indel_wide = pprsp_pkg::wide_type'(indel_ff);
   assign indel_next = (indel_wide << 3) + (indel_wide << 1) +
                       pprsp_pkg::wide_type'(item.digit);
   assign indel_sat = (indel_next[$bits(pprsp_pkg::wide_type)-1:pprsp_pkg::COUNT_BITS] != '0) ?
                      '1 : indel_next[pprsp_pkg::COUNT_BITS-1:0];
   assign phred_x = pprsp_pkg::lerr_type'(item.phred);
   assign mult_x = pprsp_pkg::lerr_type'(mult_ff);

   always_comb begin
      mode_in = mode_ff;
      tail_in = tail_ff;
      skip_in = skip_ff;
      indel_in = indel_ff;
      reads_in = reads_ff;
      quals_in = quals_ff;
      depth_in = depth_ff;
      refc_in = refc_ff;
      emit = 1'b0;
      do_normal = 1'b0;
      kind_in = pprsp_pkg::KIND_BASE;
      base_in = '0;
      index_in = '0;
      lerr_in = '0;
      status_in = pprsp_pkg::STATUS_OK;
      if (pop) begin
         unique case (item.op)
            pprsp_pkg::OP_START: begin
               refc_in = item.ref_code;
               depth_in = item.depth;
               mode_in = pprsp_pkg::MODE_NORMAL;
               skip_in = '0;
               indel_in = '0;
               reads_in = '0;
               quals_in = '0;
               tail_in = pprsp_pkg::TAIL_NONE;
            end
            pprsp_pkg::OP_READ: begin
               if (depth_ff == '0) begin
                  mode_in = mode_ff;
               end else if (mode_ff == pprsp_pkg::MODE_NORMAL && reads_ff >= depth_ff) begin
                  if (tail_ff == pprsp_pkg::TAIL_NONE || tail_ff == pprsp_pkg::TAIL_QUAL) begin
                     tail_in = is_marker ? pprsp_pkg::TAIL_MARK : pprsp_pkg::TAIL_JUNK;
                  end
               end else begin
                  unique case (mode_ff)
                     pprsp_pkg::MODE_CARET: mode_in = pprsp_pkg::MODE_NORMAL;
                     pprsp_pkg::MODE_SKIP: begin
                        skip_in = skip_dec;
                        if (skip_dec == '0) begin
                           mode_in = pprsp_pkg::MODE_NORMAL;
                        end
                     end
                     pprsp_pkg::MODE_DIGITS: begin
                        if (item.is_digit) begin
                           indel_in = indel_sat;
                        end else if (indel_ff != '0) begin
                           skip_in = indel_ff - 1'b1;
                           indel_in = '0;
                           mode_in = (indel_ff != pprsp_pkg::COUNT_BITS'(1)) ?
                                     pprsp_pkg::MODE_SKIP : pprsp_pkg::MODE_NORMAL;
                        end else begin
                           mode_in = pprsp_pkg::MODE_NORMAL;
                           do_normal = 1'b1;
                        end
                     end
                     default: begin
                        mode_in = pprsp_pkg::MODE_NORMAL;
                        do_normal = 1'b1;
                     end
                  endcase
               end
               if (do_normal) begin
                  if (item.is_caret) begin
                     mode_in = pprsp_pkg::MODE_CARET;
                  end else if (item.is_sign) begin
                     mode_in = pprsp_pkg::MODE_DIGITS;
                     indel_in = '0;
                  end else if (!item.is_dollar) begin
                     emit = 1'b1;
                     kind_in = pprsp_pkg::KIND_BASE;
                     base_in = item.is_ref ? refc_ff : item.base;
                     index_in = pprsp_pkg::index_type'(reads_ff);
                     reads_in = reads_ff + 1'b1;
                  end
               end
            end
            pprsp_pkg::OP_QUAL: begin
               if (depth_ff != '0) begin
                  if (quals_ff >= depth_ff) begin
                     if (tail_ff == pprsp_pkg::TAIL_NONE) begin
                        tail_in = pprsp_pkg::TAIL_QUAL;
                     end
                  end else begin
                     emit = 1'b1;
                     kind_in = pprsp_pkg::KIND_QUAL;
                     index_in = pprsp_pkg::index_type'(quals_ff);
                     lerr_in = phred_x * mult_x;
                     quals_in = quals_ff + 1'b1;
                  end
               end
            end
            default: begin
               emit = 1'b1;
               kind_in = pprsp_pkg::KIND_STATUS;
               if (depth_ff != '0) begin
                  if (reads_ff < depth_ff || quals_ff < depth_ff) begin
                     status_in = pprsp_pkg::STATUS_SHORT;
                  end else if (tail_ff == pprsp_pkg::TAIL_JUNK ||
                               tail_ff == pprsp_pkg::TAIL_QUAL) begin
                     status_in = pprsp_pkg::STATUS_TRAILING;
                  end
               end
               depth_in = '0;
               mode_in = pprsp_pkg::MODE_NORMAL;
               skip_in = '0;
               indel_in = '0;
               reads_in = '0;
               quals_in = '0;
               tail_in = pprsp_pkg::TAIL_NONE;
            end
         endcase
      end
      valid_in = emit || (valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= pprsp_pkg::MULT_RESET;
         mode_ff <= pprsp_pkg::MODE_NORMAL;
         tail_ff <= pprsp_pkg::TAIL_NONE;
         skip_ff <= '0;
         indel_ff <= '0;
         reads_ff <= '0;
         quals_ff <= '0;
         depth_ff <= '0;
         refc_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mult_ff <= csr_wdata;
         end
         mode_ff <= mode_in;
         tail_ff <= tail_in;
         skip_ff <= skip_in;
         indel_ff <= indel_in;
         reads_ff <= reads_in;
         quals_ff <= quals_in;
         depth_ff <= depth_in;
         refc_ff <= refc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         base_ff <= base_in;
         index_ff <= index_in;
         lerr_ff <= lerr_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.kind = kind_ff;
   assign rsp_bus.base_code = base_ff;
   assign rsp_bus.read_index = index_ff;
   assign rsp_bus.log_error = lerr_ff;
   assign rsp_bus.status = status_ff;

endmodule

>>> hw/rtl/pileup_read_string_parser_unit.sv
// Parses one pileup locus a byte per transfer and returns decoded bases, scaled
// quality values and a locus status. The unit sustains one input transfer per
// cycle while the output side is not stalled. That rate is set by the back end,
// which applies one parse-state update and one 7 by 20 bit multiply per cycle.
// A result is registered and can transfer when the output side is not stalled.
// A two-entry queue sits between the classifying front end and the back end, and
// the result is held in an output register, so input transfers continue while a
// result waits, until the queue is full.
// The user must write the error multiplier through csr_we and csr_wdata only while the unit
// is idle; the unit itself does not enforce this. No clearing pass runs after reset.
`include "pileup_read_string_parser_unit_assert.svh"

module pileup_read_string_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic signed [19:0] csr_wdata,
   pprsp_req_if.sink          req_bus,
   pprsp_rsp_if.source        rsp_bus
);

   pprsp_pkg::queue_stat_type q_stat;
   pprsp_pkg::item_type       push_item;
   pprsp_pkg::item_type       head_item;
   logic                      push;
   logic                      pop;

   pprsp_front u_front (
      .req_bus (req_bus),
      .q_stat  (q_stat),
      .push    (push),
      .item    (push_item)
   );

   pprsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   pprsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .item      (head_item),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   `PPRSP_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_stat.count <= pprsp_pkg::QCNT_BITS'(pprsp_pkg::QUEUE_DEPTH), "Queue count exceeds its depth.")
   `PPRSP_ASSERT_NEXT(a_push_fills, clock, reset, req_bus.valid && req_bus.ready, !q_stat.empty, "Accepted transfer did not reach the queue.")
   `PPRSP_ASSERT_NEXT(a_finish_reports, clock, reset, pop && head_item.op == pprsp_pkg::OP_FINISH, rsp_bus.valid && rsp_bus.kind == pprsp_pkg::KIND_STATUS, "Finish did not produce a status result.")
   `PPRSP_ASSERT_SAME(a_no_pop_stalled, clock, reset, rsp_bus.valid && !rsp_bus.ready, !pop, "Queue popped while the result was stalled.")

endmodule
